>>> sv/bmm_pkg.sv
// Shared types and address map constants for the banked memory decoder.
// No dependencies; imported by the top level.
package bmm_pkg;

  localparam int ADDR_W = 16;
  localparam int DATA_W = 8;
  localparam int CMD_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_IO    = 2'd2,
    CMD_LOAD  = 2'd3
  } cmd_t;

  // Source of the byte waiting in the read stage
  typedef enum logic [2:0] {
    SRC_NONE = 3'd0,
    SRC_ROM  = 3'd1,
    SRC_EXP  = 3'd2,
    SRC_MAIN = 3'd3,
    SRC_VID  = 3'd4
  } src_t;

  // Boot and cartridge ROM share one store covering 0x0000-0x5FFF
  localparam int ROM_DEPTH   = 24576;
  localparam int EXP_DEPTH   = 20480;
  localparam int MAIN_DEPTH  = 16384;
  localparam int PLANE_BYTES = 4416;

  localparam int ROM_AW   = $clog2(ROM_DEPTH);
  localparam int EXP_AW   = $clog2(EXP_DEPTH);
  localparam int MAIN_AW  = $clog2(MAIN_DEPTH);
  localparam int PLANE_AW = $clog2(PLANE_BYTES);

  localparam int CLEAR_LEN = ROM_DEPTH;
  localparam int CLEAR_W   = $clog2(CLEAR_LEN);

  localparam logic [ADDR_W-1:0] EXP_BASE   = 16'h6000;
  localparam logic [ADDR_W-1:0] MAIN_BASE  = 16'hB000;
  localparam logic [ADDR_W-1:0] VIDEO_BASE = 16'hEEC0;

  localparam logic [7:0] PORT_READ_PAGE  = 8'hF1;
  localparam logic [7:0] PORT_WRITE_MASK = 8'hF2;

  localparam int MASK_BITS = 6;

  localparam logic [DATA_W-1:0] OPEN_BUS = 8'hFF;

endpackage

>>> sv/bmm_ram.sv
// Generic single-port synchronous RAM, registered read, write has priority.
// No dependencies.
module bmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                           wdata,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (en) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> sv/banked_memory_map_with_vram_planes.sv
// Memory decoder with ROM, expansion RAM, main RAM and banked video planes.
// Reads: an accepted read passes the RAM read register, then the output register.
// Throughput: one request per cycle while req_stall is low; the single port of each RAM does one access a cycle.
// Reset: a clearing pass zeroes every store (ROM is kept inverted,
// so it reads 0xFF); no request is taken until it ends. Page and mask reset to zero.
// Depends on bmm_pkg and bmm_ram.
module banked_memory_map_with_vram_planes #(
  parameter int PLANE_COUNT = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [bmm_pkg::CMD_W-1:0]   command,
  input  logic [bmm_pkg::ADDR_W-1:0]  address,
  input  logic [bmm_pkg::DATA_W-1:0]  data_in,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [bmm_pkg::DATA_W-1:0]  read_data
);

  import bmm_pkg::*;

  localparam int PW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

  logic               clearing;
  logic [CLEAR_W-1:0] clear_idx;

  logic [7:0]           read_page;
  logic [MASK_BITS-1:0] write_mask;

  logic          s1_valid;
  src_t          s1_src;
  logic [PW-1:0] s1_plane;

  logic        acc, do_read, do_write, do_io, do_load;
  logic        is_rom, is_exp, is_main, is_vid, page_ok;
  logic        s1_adv;
  src_t        src_next;
  logic [DATA_W-1:0] s1_value;

  logic [ADDR_W-1:0] exp_off, main_off, vid_off;

  logic              rom_en, rom_we, exp_en, exp_we, main_en, main_we;
  logic [ROM_AW-1:0]  rom_addr;
  logic [EXP_AW-1:0]  exp_addr;
  logic [MAIN_AW-1:0] main_addr;
  logic [PLANE_AW-1:0] vid_addr;
  logic [DATA_W-1:0] rom_wdata, ram_wdata, rom_q, exp_q, main_q;
  logic [DATA_W-1:0] plane_q [PLANE_COUNT];

  // Request decode
  assign acc      = req_valid && !req_stall;
  assign do_read  = acc && (command == CMD_READ);
  assign do_write = acc && (command == CMD_WRITE);
  assign do_io    = acc && (command == CMD_IO);
  assign do_load  = acc && (command == CMD_LOAD);

  assign is_rom  = address < EXP_BASE;
  assign is_exp  = (address >= EXP_BASE) && (address < MAIN_BASE);
  assign is_main = (address >= MAIN_BASE) && (address < VIDEO_BASE);
  assign is_vid  = address >= VIDEO_BASE;
  assign page_ok = (read_page != 8'd0) && (read_page <= 8'(PLANE_COUNT));

  assign exp_off  = address - EXP_BASE;
  assign main_off = address - MAIN_BASE;
  assign vid_off  = address - VIDEO_BASE;

  always_comb begin
    if (is_rom) begin
      src_next = SRC_ROM;
    end else if (is_exp) begin
      src_next = SRC_EXP;
    end else if (is_main) begin
      src_next = SRC_MAIN;
    end else if (page_ok) begin
      src_next = SRC_VID;
    end else begin
      src_next = SRC_NONE;
    end
  end

  // Read stage moves on when the output register is free or being taken
  assign s1_adv    = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = clearing || (s1_valid && rsp_valid && rsp_stall);

  // Memory ports: the clearing pass writes zero, ROM data is stored inverted
  assign rom_addr  = clearing ? clear_idx : address[ROM_AW-1:0];
  assign exp_addr  = clearing ? clear_idx[EXP_AW-1:0] : exp_off[EXP_AW-1:0];
  assign main_addr = clearing ? clear_idx[MAIN_AW-1:0] : main_off[MAIN_AW-1:0];
  assign vid_addr  = clearing ? clear_idx[PLANE_AW-1:0] : vid_off[PLANE_AW-1:0];
  assign rom_wdata = clearing ? '0 : ~data_in;
  assign ram_wdata = clearing ? '0 : data_in;

  assign rom_we  = clearing || (do_load && is_rom);
  assign rom_en  = rom_we || (do_read && is_rom);
  assign exp_we  = (clearing && (clear_idx < CLEAR_W'(EXP_DEPTH))) || (do_write && is_exp);
  assign exp_en  = exp_we || (do_read && is_exp);
  assign main_we = (clearing && (clear_idx < CLEAR_W'(MAIN_DEPTH))) || (do_write && is_main);
  assign main_en = main_we || (do_read && is_main);

  bmm_ram #(.WIDTH(DATA_W), .DEPTH(ROM_DEPTH)) u_rom (
    .clk(clk), .en(rom_en), .we(rom_we), .addr(rom_addr), .wdata(rom_wdata), .rdata(rom_q)
  );

  bmm_ram #(.WIDTH(DATA_W), .DEPTH(EXP_DEPTH)) u_exp (
    .clk(clk), .en(exp_en), .we(exp_we), .addr(exp_addr), .wdata(ram_wdata), .rdata(exp_q)
  );

  bmm_ram #(.WIDTH(DATA_W), .DEPTH(MAIN_DEPTH)) u_main (
    .clk(clk), .en(main_en), .we(main_we), .addr(main_addr), .wdata(ram_wdata),
    .rdata(main_q)
  );

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    logic pl_we, pl_en, mask_hit;
    // planes beyond the mask width are never written by the CPU
    if (p < MASK_BITS) begin : g_mask
      assign mask_hit = write_mask[p];
    end else begin : g_nomask
      assign mask_hit = 1'b0;
    end
    assign pl_we = (clearing && (clear_idx < CLEAR_W'(PLANE_BYTES)))
                   || (do_write && is_vid && mask_hit);
    assign pl_en = pl_we || (do_read && is_vid);
    bmm_ram #(.WIDTH(DATA_W), .DEPTH(PLANE_BYTES)) u_plane (
      .clk(clk), .en(pl_en), .we(pl_we), .addr(vid_addr), .wdata(ram_wdata),
      .rdata(plane_q[p])
    );
  end

  always_comb begin
    case (s1_src)
      SRC_ROM:  s1_value = ~rom_q;
      SRC_EXP:  s1_value = exp_q;
      SRC_MAIN: s1_value = main_q;
      SRC_VID:  s1_value = plane_q[s1_plane];
      default:  s1_value = OPEN_BUS;
    endcase
  end

  // Clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_idx <= '0;
    end else if (clearing) begin
      clear_idx <= clear_idx + 1'b1;
      if (clear_idx == CLEAR_W'(CLEAR_LEN - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // I/O registers
  always_ff @(posedge clk) begin
    if (rst) begin
      read_page  <= '0;
      write_mask <= '0;
    end else if (do_io) begin
      if (address[7:0] == PORT_READ_PAGE) begin
        read_page <= data_in;
      end else if (address[7:0] == PORT_WRITE_MASK) begin
        write_mask <= data_in[MASK_BITS-1:0];
      end
    end
  end

  // Read stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (do_read) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      s1_src   <= src_next;
      s1_plane <= PW'(read_page - 8'd1);
    end
    if (s1_adv) begin
      read_data <= s1_value;
    end
  end

  a_read_enters_stage: assert property (@(posedge clk) disable iff (rst)
    do_read |=> s1_valid)
    else $error("accepted read did not reach the read stage");

  a_blocked_read_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && rsp_valid && rsp_stall) |=> s1_valid)
    else $error("blocked read dropped");

  a_clear_full_length: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> ($past(clear_idx) == CLEAR_W'(CLEAR_LEN - 1)))
    else $error("clearing pass ended early");

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!rsp_valid && !s1_valid))
    else $error("result present during clearing pass");

endmodule
